FILE: hdl/stsp_pkg.sv
// Shared types and constants for the trapezoidal step planner.
// Used by stsp_ctrl, stsp_dpath and the top level; no dependencies.

package stsp_pkg;

  localparam logic [19:0] ONE_MILLION = 20'd1000000;

  // accel*t / 1e6 is taken as (accel*t >> 6) / 15625 by reciprocal multiply
  localparam logic [13:0] V_DIVISOR = 14'd15625;
  localparam logic [31:0] V_RECIP   = 32'd2251799813;  // floor(2^45 / 15625)

  // register reset values
  localparam logic [23:0] ACCEL_RST     = 24'd1000;
  localparam logic [19:0] MAX_SPEED_RST = 20'd1000;
  localparam logic [31:0] INIT_IVL_RST  = 32'd44721;

  // iteration counts of the shared arithmetic
  localparam int MUL_ITERS  = 24;  // accel bits, shift-add multiply
  localparam int VDIV_ITERS = 3;   // estimate, remainder, correction of accel*t / 1e6
  localparam int IDIV_ITERS = 20;  // quotient bits of 1e6 / velocity
  localparam int CNT_W      = 5;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [1:0] {
    CFG_ACCEL     = 2'd0,
    CFG_MAX_SPEED = 2'd1,
    CFG_INIT_IVL  = 2'd2,
    CFG_DIR_INV   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_INIT   = 3'd0,
    PH_ACCEL  = 3'd1,
    PH_CRUISE = 3'd2,
    PH_DECEL  = 3'd3,
    PH_PAD    = 3'd4
  } phase_t;

  typedef struct packed {
    logic take_in;
    logic start;
    logic step;
    logic mul_run;
    logic vchk;
    logic dv_run;
    logic sel;
    logic di_run;
    logic update;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic will_step;
    logic home_stop;
    logic need_mul;
    logic sat;
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hdl/stsp_ctrl.sv
// Sequencer of the step planner: each request gets decode, then as needed
// step, multiply, two divisions, update; then hand-off. Depends on stsp_pkg.

module stsp_ctrl import stsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_START = 10'b00_0000_0010,
    S_STEP  = 10'b00_0000_0100,
    S_MUL   = 10'b00_0000_1000,
    S_VCHK  = 10'b00_0001_0000,
    S_DV    = 10'b00_0010_0000,
    S_SEL   = 10'b00_0100_0000,
    S_DI    = 10'b00_1000_0000,
    S_UPD   = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.take_in = 1'b1;
          state_next  = S_START;
        end
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = stat.will_step ? S_STEP : S_OUT;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (stat.home_stop)     state_next = S_OUT;
        else if (stat.need_mul) state_next = S_MUL;
        else                    state_next = S_UPD;
      end
      S_MUL: begin
        cmd.mul_run = 1'b1;
        if (stat.last) state_next = S_VCHK;
      end
      S_VCHK: begin
        cmd.vchk   = 1'b1;
        state_next = stat.sat ? S_SEL : S_DV;
      end
      S_DV: begin
        cmd.dv_run = 1'b1;
        if (stat.last) state_next = S_SEL;
      end
      S_SEL: begin
        cmd.sel    = 1'b1;
        state_next = S_DI;
      end
      S_DI: begin
        cmd.di_run = 1'b1;
        if (stat.last) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_START))
    else $error("accepted request did not enter decode");

  a_idle_request: assert property (@(posedge clk) disable iff (rst)
    (state == S_START && !stat.will_step) |=> (state == S_OUT))
    else $error("request without step did not go to result");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !stat.out_free) |=> (state == S_OUT))
    else $error("result left before output register was free");

endmodule

FILE: hdl/stsp_dpath.sv
// Datapath of the step planner: config and motion registers, shift-add
// multiplier, reciprocal divide by 1e6, restoring divider, output register.
// Depends on stsp_pkg.

module stsp_dpath import stsp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [0:0]             s_tuser,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  input  logic                   m_tready,
  output logic                   m_tvalid,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  // configuration
  logic [23:0] accel;
  logic [19:0] max_speed;
  logic [31:0] init_ivl;
  logic        dir_inv;

  // latched request
  logic        in_mode;
  logic [31:0] in_dist;
  logic        in_homing;
  logic [19:0] in_hspeed;
  logic        in_sw;

  // motion state
  phase_t      phase;
  logic        busy_flag;
  logic        homing_flag;
  logic        dir_level;
  logic [31:0] steps_done;
  logic [31:0] steps_target;
  logic [31:0] decel_start;
  logic [47:0] elapsed;
  logic [47:0] decel_time;
  logic [31:0] step_ivl;
  logic [31:0] velocity;
  logic [19:0] run_speed;
  logic [31:0] abs_pos;
  logic        res_pulse;
  logic [31:0] res_ivl;

  // arithmetic
  logic [47:0]      mul_t;
  logic [71:0]      prod;
  logic [16:0]      vrem;   // remainder left after the quotient estimate
  logic [31:0]      vdvd;   // quotient estimate, then quotient
  logic [31:0]      irem;
  logic [19:0]      idvd;   // dividend in, quotient out
  logic [CNT_W-1:0] cnt;
  logic             cruise_hit;

  logic [48:0] mul_sum;
  logic [63:0] q_prod;
  logic [31:0] q_est;
  logic [45:0] q_back;
  logic [45:0] v_diff;
  logic [16:0] rem_est;
  logic [2:0]  v_fix;
  logic [32:0] i_sh;
  logic        i_ge;
  logic [32:0] i_sub;
  logic [31:0] v_fl;
  logic [31:0] rs_fl;
  logic        decel_hit;
  logic        go_cruise;
  logic [31:0] ivl_a;
  logic        dec_end;
  logic [31:0] ivl_u;
  logic [47:0] dt_sub;
  logic        reach;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel     <= ACCEL_RST;
      max_speed <= MAX_SPEED_RST;
      init_ivl  <= INIT_IVL_RST;
      dir_inv   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ACCEL:     accel     <= cfg_data[23:0];
        CFG_MAX_SPEED: max_speed <= cfg_data[19:0];
        CFG_INIT_IVL:  init_ivl  <= cfg_data;
        CFG_DIR_INV:   dir_inv   <= cfg_data[0];
      endcase
    end
  end

  // status
  assign stat.will_step = (!in_mode && !busy_flag && (in_homing || in_dist != 32'd0)) ||
                          (in_mode && busy_flag);
  assign stat.home_stop = homing_flag && in_sw;
  assign stat.need_mul  = (phase == PH_ACCEL) || (phase == PH_DECEL);
  assign stat.sat       = prod[71:32] >= {20'd0, ONE_MILLION};
  assign stat.last      = (cnt == '0);
  assign stat.out_free  = !m_tvalid || m_tready;

  // arithmetic steps
  assign mul_sum = {1'b0, prod[71:24]} + (prod[0] ? {1'b0, mul_t} : 49'd0);

  // unsaturated product is below 15625 * 2^38, so prod[51:6] holds it >> 6;
  // the estimate undershoots the quotient by at most 4
  assign q_prod  = {32'd0, prod[51:20]} * {32'd0, V_RECIP};
  assign q_est   = q_prod[62:31];
  assign q_back  = {14'd0, vdvd} * {32'd0, V_DIVISOR};
  assign v_diff  = prod[51:6] - q_back;
  assign rem_est = v_diff[16:0];

  always_comb begin
    priority if (vrem >= 17'(4 * V_DIVISOR)) v_fix = 3'd4;
    else if (vrem >= 17'(3 * V_DIVISOR))     v_fix = 3'd3;
    else if (vrem >= 17'(2 * V_DIVISOR))     v_fix = 3'd2;
    else if (vrem >= {3'd0, V_DIVISOR})      v_fix = 3'd1;
    else                                     v_fix = 3'd0;
  end

  assign i_sh    = {irem, idvd[19]};
  assign i_ge    = i_sh >= {1'b0, velocity};
  assign i_sub   = i_sh - {1'b0, velocity};

  assign v_fl      = (vdvd == 32'd0) ? 32'd1 : vdvd;
  assign rs_fl     = (run_speed == 20'd0) ? 32'd1 : {12'd0, run_speed};
  assign decel_hit = !homing_flag && (steps_done >= {1'b0, steps_target[31:1]});
  assign go_cruise = (phase == PH_ACCEL) && !decel_hit && (v_fl >= {12'd0, run_speed});

  always_comb begin
    unique case (phase)
      PH_INIT:            ivl_a = init_ivl;
      PH_ACCEL, PH_DECEL: ivl_a = {12'd0, idvd};
      default:            ivl_a = step_ivl;
    endcase
  end

  assign dec_end = (phase == PH_DECEL) && ({16'd0, ivl_a} >= decel_time);
  assign ivl_u   = dec_end ? init_ivl : ivl_a;
  assign dt_sub  = (decel_time > {16'd0, ivl_u}) ? (decel_time - {16'd0, ivl_u}) : 48'd0;
  assign reach   = !homing_flag && (steps_done >= steps_target);

  // request payload
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      in_mode   <= s_tuser[0];
      in_dist   <= s_tdata[31:0];
      in_homing <= s_tdata[32];
      in_hspeed <= s_tdata[52:33];
      in_sw     <= s_tdata[53];
    end
  end

  // motion state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_INIT;
      busy_flag    <= 1'b0;
      homing_flag  <= 1'b0;
      dir_level    <= 1'b0;
      steps_done   <= '0;
      steps_target <= '0;
      decel_start  <= '0;
      elapsed      <= '0;
      decel_time   <= '0;
      step_ivl     <= '0;
      run_speed    <= '0;
      abs_pos      <= '0;
      res_pulse    <= 1'b0;
      res_ivl      <= '0;
    end else if (cmd.start) begin
      res_pulse <= 1'b0;
      res_ivl   <= '0;
      if (!in_mode && !busy_flag) begin
        phase       <= PH_INIT;
        steps_done  <= '0;
        elapsed     <= '0;
        decel_time  <= '0;
        decel_start <= '0;
        if (in_homing) begin
          run_speed    <= (in_hspeed != 20'd0) ? in_hspeed : {1'b0, max_speed[19:1]};
          homing_flag  <= 1'b1;
          steps_target <= 32'd1;
          dir_level    <= 1'b0;
          abs_pos      <= abs_pos - 32'd1;
          busy_flag    <= 1'b1;
        end else begin
          run_speed    <= max_speed;
          homing_flag  <= 1'b0;
          dir_level    <= !in_dist[31];
          steps_target <= in_dist[31] ? (32'd0 - in_dist) : in_dist;
          abs_pos      <= abs_pos + in_dist;
          busy_flag    <= (in_dist != 32'd0);
        end
      end
    end else if (cmd.step) begin
      if (stat.home_stop) begin
        busy_flag   <= 1'b0;
        homing_flag <= 1'b0;
        abs_pos     <= '0;
      end else begin
        steps_done <= steps_done + 32'd1;
        res_pulse  <= 1'b1;
      end
    end else if (cmd.update) begin
      step_ivl <= ivl_u;
      unique case (phase)
        PH_INIT: phase <= PH_ACCEL;
        PH_ACCEL: begin
          if (decel_hit) begin
            phase      <= PH_DECEL;
            decel_time <= elapsed;
          end else if (cruise_hit) begin
            decel_start <= steps_target - steps_done;
            decel_time  <= elapsed;
            phase       <= PH_CRUISE;
          end
        end
        PH_CRUISE: begin
          if (!homing_flag && steps_done >= decel_start) phase <= PH_DECEL;
        end
        PH_DECEL: begin
          if (dec_end) phase <= PH_PAD;
          decel_time <= dt_sub;
        end
        default: ;
      endcase
      if (reach) begin
        busy_flag <= 1'b0;
      end else begin
        elapsed <= elapsed + {16'd0, ivl_u};
        res_ivl <= ivl_u;
      end
    end
  end

  // multiplier and dividers
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      mul_t <= (phase == PH_DECEL) ? decel_time : elapsed;
      prod  <= {48'd0, accel};
      cnt   <= CNT_W'(MUL_ITERS - 1);
    end else if (cmd.mul_run) begin
      prod <= {mul_sum, prod[23:1]};
      cnt  <= cnt - 1'b1;
    end else if (cmd.vchk) begin
      // saturated value; replaced by the quotient when not saturated
      vdvd <= 32'hFFFF_FFFF;
      cnt  <= CNT_W'(VDIV_ITERS - 1);
    end else if (cmd.dv_run) begin
      if (cnt == CNT_W'(2))      vdvd <= q_est;
      else if (cnt == CNT_W'(1)) vrem <= rem_est;
      else                       vdvd <= vdvd + {29'd0, v_fix};
      cnt <= cnt - 1'b1;
    end else if (cmd.sel) begin
      velocity   <= go_cruise ? rs_fl : v_fl;
      cruise_hit <= go_cruise;
      irem       <= '0;
      idvd       <= ONE_MILLION;
      cnt        <= CNT_W'(IDIV_ITERS - 1);
    end else if (cmd.di_run) begin
      irem <= i_ge ? i_sub[31:0] : i_sh[31:0];
      idvd <= {idvd[18:0], i_ge};
      cnt  <= cnt - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {5'd0, abs_pos, busy_flag, res_ivl, dir_level ^ dir_inv, res_pulse};
    end
  end

  a_vrem_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.dv_run && stat.last) |-> (vrem < 17'(5 * V_DIVISOR)))
    else $error("velocity quotient estimate off by more than four");

  a_irem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.di_run |-> (velocity != 32'd0 && irem < velocity))
    else $error("interval divider remainder out of range");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> m_tvalid)
    else $error("result not presented after load");

endmodule

FILE: hdl/stepper_trapezoid_step_planner_unit.sv
// Top level of the trapezoidal step planner: request and result streams,
// config write port. Depends on stsp_pkg, stsp_ctrl and stsp_dpath.
//
// Usage:
//  - Requests enter on s_tvalid/s_tready. s_tuser[0] is the mode: 0 starts a
//    move or homing command, 1 is a step-due event. Every request yields one
//    result on m_tvalid/m_tready.
//  - A request that issues a step in the acceleration or deceleration phase
//    runs the shift-add multiply of acceleration by time, the reciprocal
//    divide by 1e6 and the division 1e6 / velocity, besides decode, step,
//    check, select, update and hand-off; the divide by 1e6 is skipped when
//    the velocity saturates. Other requests skip the arithmetic. One
//    request is in work at a time.
//  - The result sits in an output register; the next request is accepted
//    while it waits. A stalled receiver holds the sequencer only when the
//    following result is ready to be written.
//  - cfg_we writes register cfg_index (0 acceleration, 1 max speed, 2 initial
//    interval, 3 direction invert); write only while idle (not enforced).
//  - Synchronous reset rst clears motion state and loads register defaults.

module stepper_trapezoid_step_planner_unit import stsp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [31:0] distance, [32] homing, [52:33] home_speed, [53] home_switch
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // [0] mode
  input  logic [0:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [0] step_pulse, [1] direction, [33:2] next_interval, [34] busy_res,
  // [66:35] position
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  stsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  stsp_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

endmodule
